@@ src/user_id_set_table_macros.svh @@
// Assertion macros for the user ID set table.
`ifndef USER_ID_SET_TABLE_MACROS_SVH
`define USER_ID_SET_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge out of reset
`define USIDTAB_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("usidtab: invariant violated");

// when ante holds, cons must hold in the same cycle
`define USIDTAB_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("usidtab: implication violated");

`else

`define USIDTAB_ASSERT_ALWAYS(label, clk, rstn, expr)
`define USIDTAB_ASSERT_IMPLY(label, clk, rstn, ante, cons)

`endif

`endif

@@ src/usidtab_pkg.sv @@
`timescale 1ns / 1ps

package usidtab_pkg;

    localparam int ENTRIES = 64;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int ACT_W  = 2;
    localparam int ID_W   = 31;
    localparam int ST_W   = 2;
    localparam int MCNT_W = 7;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_LIST   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_PROTECTED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  user_id;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [MCNT_W-1:0] member_count;
        logic [ID_W-1:0]   listed_id;
        logic              last_result;
    } out_item_t;

endpackage

@@ src/usidtab_ram.sv @@
`timescale 1ns / 1ps

module usidtab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/user_id_set_table.sv @@
`timescale 1ns / 1ps
`include "user_id_set_table_macros.svh"

// User ID set table.
// Input channel s_valid/s_ready/s_data carries one request transaction:
// an action (lookup, add, remove, list) and a 31-bit user ID. Result
// channel m_valid/m_ready/m_data returns status, member count after the
// request, a listed ID and a last-result flag.
// The IDs live in a single-port-read ID memory (registered read); valid
// marks and the member count sit in flops. Every request sweeps the ID
// memory one entry per cycle while no pending result stalls it, and the
// next request can be accepted once the sweep is over: lookup/add/remove
// stop at the matching entry, remove of ID 0 finishes at entry 0. List
// emits one result per valid entry as the sweep passes it.
// s_ready is high only while no request is in progress; one request is
// handled at a time. The result register lets a new request be accepted
// while the last result still waits.
// When m_ready is low with a result pending, the sweep freezes in place
// and resumes when the result is taken; nothing is dropped.
// Reset (aresetn low, synchronous) leaves entry 0 valid holding ID 0, all
// other entries empty, count 1. No memory clearing pass is needed.

module user_id_set_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  usidtab_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output usidtab_pkg::out_item_t m_data
);

    localparam int ENTRIES = usidtab_pkg::ENTRIES;
    localparam int ADDR_W  = usidtab_pkg::ADDR_W;
    localparam int CNT_W   = usidtab_pkg::CNT_W;
    localparam int ID_W    = usidtab_pkg::ID_W;
    localparam int ACT_W   = usidtab_pkg::ACT_W;
    localparam int MCNT_W  = usidtab_pkg::MCNT_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(ENTRIES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  state_reg, state_next;
    logic [ACT_W-1:0]      act_reg, act_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [CNT_W-1:0]      rd_addr_reg, rd_addr_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]     cmp_addr_reg, cmp_addr_next;
    logic                  free_found_reg, free_found_next;
    logic [ADDR_W-1:0]     free_slot_reg, free_slot_next;
    logic [CNT_W-1:0]      list_n_reg, list_n_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ENTRIES-1:0]    vld_reg, vld_next;
    logic                  id0_wr_reg, id0_wr_next;
    logic                  m_valid_reg, m_valid_next;
    usidtab_pkg::out_item_t out_reg, out_next;

    logic              adv;
    logic              emit;
    logic              finish;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   ram_rd_data;
    logic [ID_W-1:0]   ent_id;
    logic              ent_v;
    logic              hit;
    logic              free_any;
    logic [ADDR_W-1:0] free_at;
    logic              zero_remove;

    usidtab_ram #(
        .WIDTH (ID_W),
        .DEPTH (ENTRIES)
    ) u_id_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (id_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // sweep moves only when the result register can take a new transaction
    assign adv = !m_valid_reg || m_ready;

    // entry 0 holds ID 0 from reset until it is first written
    assign ent_id      = (cmp_addr_reg == '0 && !id0_wr_reg) ? '0 : ram_rd_data;
    assign ent_v       = vld_reg[cmp_addr_reg];
    assign hit         = ent_v && (ent_id == id_reg);
    assign free_any    = free_found_reg || !ent_v;
    assign free_at     = free_found_reg ? free_slot_reg : cmp_addr_reg;
    assign zero_remove = (act_reg == usidtab_pkg::ACT_REMOVE) && (id_reg == '0);

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        id_next         = id_reg;
        rd_addr_next    = rd_addr_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_addr_next   = cmp_addr_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        list_n_next     = list_n_reg;
        cnt_next        = cnt_reg;
        vld_next        = vld_reg;
        id0_wr_next     = id0_wr_reg;
        out_next        = out_reg;
        emit            = 1'b0;
        finish          = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = free_at;

        if (state_reg == S_IDLE) begin
            if (s_valid) begin
                act_next        = s_data.action;
                id_next         = s_data.user_id;
                rd_addr_next    = '0;
                cmp_vld_next    = 1'b0;
                free_found_next = 1'b0;
                list_n_next     = '0;
                state_next      = S_SCAN;
            end
        end else if (adv) begin
            // compare stage: entry cmp_addr_reg, data from the last read issued
            if (cmp_vld_reg) begin
                if (act_reg == usidtab_pkg::ACT_LIST) begin
                    if (ent_v) begin
                        emit                  = 1'b1;
                        out_next.status       = usidtab_pkg::ST_OK;
                        out_next.member_count = MCNT_W'(cnt_reg);
                        out_next.listed_id    = ent_id;
                        out_next.last_result  = ((list_n_reg + CNT_W'(1)) == cnt_reg);
                        list_n_next           = list_n_reg + CNT_W'(1);
                        finish                = out_next.last_result;
                    end else if (cmp_addr_reg == LAST_ADDR && list_n_reg == '0) begin
                        // empty table: single not-found result
                        emit                  = 1'b1;
                        out_next.status       = usidtab_pkg::ST_NOT_FOUND;
                        out_next.member_count = '0;
                        out_next.listed_id    = '0;
                        out_next.last_result  = 1'b1;
                    end
                    if (cmp_addr_reg == LAST_ADDR) begin
                        finish = 1'b1;
                    end
                end else begin
                    if (!ent_v && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_addr_reg;
                    end
                    if (hit || cmp_addr_reg == LAST_ADDR || zero_remove) begin
                        finish               = 1'b1;
                        emit                 = 1'b1;
                        out_next.listed_id   = '0;
                        out_next.last_result = 1'b1;
                        out_next.status      = usidtab_pkg::ST_OK;
                        unique case (act_reg)
                            usidtab_pkg::ACT_LOOKUP: begin
                                out_next.status = hit ? usidtab_pkg::ST_OK
                                                      : usidtab_pkg::ST_NOT_FOUND;
                            end
                            usidtab_pkg::ACT_ADD: begin
                                if (!hit) begin
                                    if (free_any) begin
                                        wr_en             = 1'b1;
                                        vld_next[free_at] = 1'b1;
                                        cnt_next          = cnt_reg + CNT_W'(1);
                                        if (free_at == '0) begin
                                            id0_wr_next = 1'b1;
                                        end
                                    end else begin
                                        out_next.status = usidtab_pkg::ST_FULL;
                                    end
                                end
                            end
                            usidtab_pkg::ACT_REMOVE: begin
                                if (zero_remove) begin
                                    out_next.status = usidtab_pkg::ST_PROTECTED;
                                end else if (hit) begin
                                    vld_next[cmp_addr_reg] = 1'b0;
                                    cnt_next               = cnt_reg - CNT_W'(1);
                                end else begin
                                    out_next.status = usidtab_pkg::ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                out_next.status = usidtab_pkg::ST_OK;
                            end
                        endcase
                        out_next.member_count = MCNT_W'(cnt_next);
                    end
                end
            end

            // read issue stage
            if (!finish && rd_addr_reg < SCAN_END) begin
                rd_en         = 1'b1;
                cmp_vld_next  = 1'b1;
                cmp_addr_next = rd_addr_reg[ADDR_W-1:0];
                rd_addr_next  = rd_addr_reg + CNT_W'(1);
            end else begin
                cmp_vld_next = 1'b0;
            end

            if (finish) begin
                state_next = S_IDLE;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            list_n_reg     <= '0;
            cnt_reg        <= CNT_W'(1);
            vld_reg        <= ENTRIES'(1);
            id0_wr_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            rd_addr_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            list_n_reg     <= list_n_next;
            cnt_reg        <= cnt_next;
            vld_reg        <= vld_next;
            id0_wr_reg     <= id0_wr_next;
            m_valid_reg    <= m_valid_next;
            rd_addr_reg    <= rd_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        id_reg        <= id_next;
        cmp_addr_reg  <= cmp_addr_next;
        free_slot_reg <= free_slot_next;
        out_reg       <= out_next;
    end

    `USIDTAB_ASSERT_ALWAYS(a_entry0_kept, aclk, aresetn, vld_reg[0])
    `USIDTAB_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, cnt_reg <= SCAN_END)
    `USIDTAB_ASSERT_IMPLY(a_idle_no_read, aclk, aresetn, state_reg == S_IDLE, !cmp_vld_reg)
    `USIDTAB_ASSERT_IMPLY(a_full_count, aclk, aresetn, m_valid && m_data.status == usidtab_pkg::ST_FULL, cnt_reg == SCAN_END)

endmodule
